// File: rtl/core/pdec_pkg.sv
// Shared types, character constants and hex helper for the percent decoder.
package pdec_pkg;

    localparam logic [7:0] C_PLUS    = 8'h2B;
    localparam logic [7:0] C_PERCENT = 8'h25;
    localparam logic [7:0] C_SPACE   = 8'h20;
    localparam logic [7:0] C_DIG0    = 8'h30;
    localparam logic [7:0] C_DIG9    = 8'h39;
    localparam logic [7:0] C_UPA     = 8'h41;
    localparam logic [7:0] C_UPF     = 8'h46;
    localparam logic [7:0] C_LOA     = 8'h61;
    localparam logic [7:0] C_LOF     = 8'h66;
    localparam logic [3:0] C_TEN     = 4'd10;

    localparam logic [15:0] CAP_RESET = 16'd256;

    // Escape phase codes
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PCT   = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_NONE  = 2'd3;

    // Results caused by one input item: up to three bytes, then an optional terminator
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      nbytes;
        logic            term;
    } t_group;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (b inside {[C_DIG0:C_DIG9]}) begin
            h.value = 4'(b - C_DIG0);
        end else if (b inside {[C_UPA:C_UPF]}) begin
            h.value = 4'(b - C_UPA) + C_TEN;
        end else if (b inside {[C_LOA:C_LOF]}) begin
            h.value = 4'(b - C_LOA) + C_TEN;
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

endpackage

// File: rtl/core/pdec_decode.sv
// Escape state, emission count and per-item result group builder.
module pdec_decode import pdec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic        i_last,
    input  logic [15:0] i_capacity,
    output t_group      o_group,
    output logic        o_group_nonempty
);

    logic [1:0]  r_phase, n_phase;
    logic [7:0]  r_held, n_held;
    logic [15:0] r_count, n_count;

    t_hex             hx, hheld;
    logic             plain_has, plain_esc;
    logic [7:0]       plain_b;
    logic [2:0][7:0]  cand;
    logic [1:0]       cand_n;
    logic [2:0]       room_ok;
    logic [1:0]       room_n, emit_n;

    // Classify the byte as plain input
    always_comb begin
        hx        = hex_decode(i_byte);
        hheld     = hex_decode(r_held);
        plain_esc = 1'b0;
        plain_has = 1'b1;
        plain_b   = i_byte;
        if (i_byte == C_PLUS) begin
            plain_b = C_SPACE;
        end else if (i_byte == C_PERCENT && !i_last) begin
            plain_esc = 1'b1;
            plain_has = 1'b0;
        end
    end

    // Build candidate bytes and next escape state
    always_comb begin
        cand    = '0;
        cand_n  = 2'd0;
        n_phase = PH_IDLE;
        n_held  = r_held;
        case (r_phase)
            PH_PCT: begin
                if (!i_last && hx.valid) begin
                    n_held  = i_byte;
                    n_phase = PH_DIGIT;
                end else begin
                    cand[0] = C_PERCENT;
                    cand[1] = plain_b;
                    cand_n  = plain_has ? 2'd2 : 2'd1;
                    n_phase = plain_esc ? PH_PCT : PH_IDLE;
                end
            end
            PH_DIGIT: begin
                n_held = 8'd0;
                if (hx.valid) begin
                    cand[0] = {hheld.value, hx.value};
                    cand_n  = 2'd1;
                end else begin
                    cand[0] = C_PERCENT;
                    cand[1] = r_held;
                    cand[2] = plain_b;
                    cand_n  = plain_has ? 2'd3 : 2'd2;
                    n_phase = plain_esc ? PH_PCT : PH_IDLE;
                end
            end
            default: begin
                cand[0] = plain_b;
                cand_n  = plain_has ? 2'd1 : 2'd0;
                n_phase = plain_esc ? PH_PCT : PH_IDLE;
            end
        endcase
        if (i_last) begin
            n_phase = PH_IDLE;
            n_held  = 8'd0;
        end
    end

    // Clip emissions to the remaining capacity
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            room_ok[i] = ({1'b0, r_count} + 17'(i + 1)) < {1'b0, i_capacity};
        end
        room_n = room_ok[0] ? (room_ok[1] ? (room_ok[2] ? 2'd3 : 2'd2) : 2'd1) : 2'd0;
        emit_n = (cand_n < room_n) ? cand_n : room_n;
        n_count = i_last ? 16'd0 : r_count + 16'(emit_n);
    end

    assign o_group.bytes     = cand;
    assign o_group.nbytes    = emit_n;
    assign o_group.term      = i_last;
    assign o_group_nonempty  = (emit_n != 2'd0) || i_last;

    // Advance state on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
            r_count <= 16'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_phase3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase != PH_NONE)
        else $error("escape phase reached unused code");
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_last |=> r_phase == PH_IDLE && r_count == 16'd0)
        else $error("final beat did not clear string state");
    a_held_hex: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DIGIT |-> hheld.valid)
        else $error("held digit is not hex");
`endif

endmodule

// File: rtl/core/pdec_outq.sv
// Result group register that drains one result beat per cycle while i_ready is high.
module pdec_outq import pdec_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_group     i_group,
    output logic       o_can_load,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_byte,
    output logic       o_term,
    output logic       o_last
);

    logic       r_valid;
    t_group     r_grp;
    logic [1:0] r_idx;
    logic [2:0] total;
    logic       last_beat, take, is_term;

    assign total      = {1'b0, r_grp.nbytes} + {2'b00, r_grp.term};
    assign last_beat  = ({1'b0, r_idx} + 3'd1) == total;
    assign take       = r_valid && i_ready;
    assign o_can_load = !r_valid || (take && last_beat);
    assign is_term    = {1'b0, r_idx} >= {1'b0, r_grp.nbytes};

    assign o_valid = r_valid;
    assign o_byte  = is_term ? 8'd0 : r_grp.bytes[r_idx];
    assign o_term  = is_term;
    assign o_last  = last_beat;

    // Load a new group or step through the held one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= 2'd0;
        end else if (take) begin
            if (last_beat) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // Hold payload for the group
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_grp <= i_group;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_in_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ({1'b0, r_idx} < total))
        else $error("result index beyond group");
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_can_load)
        else $error("group loaded over undelivered results");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && !last_beat |=> r_valid && r_idx == $past(r_idx) + 2'd1)
        else $error("result index did not advance");
`endif

endmodule

// File: rtl/core/percent_decoder.sv
// Top level of the form-URL percent decoder stream block.
// The first result beat of an input beat is registered and presented in the cycle after the input beat is accepted.
// One input beat per cycle while each beat yields at most one result and the output is ready;
// a beat yielding more results (up to four) holds off input until its last result is taken,
// since the single result group register drains one beat per cycle while the output is ready.
// Reset: synchronous active low; clears escape state and count, capacity 256.
module percent_decoder import pdec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // final_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tuser,   // [0] is_terminator
    output logic        m_axis_tlast,   // run_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data      // [15:0] out_capacity
);

    logic [15:0] r_capacity;
    t_group      grp;
    logic        grp_nonempty, can_load, accept;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    // Hold the capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= CAP_RESET;
        end else if (i_cfg_valid) begin
            r_capacity <= i_cfg_data;
        end
    end

    pdec_decode u_decode (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_byte           (s_axis_tdata),
        .i_last           (s_axis_tlast),
        .i_capacity       (r_capacity),
        .o_group          (grp),
        .o_group_nonempty (grp_nonempty)
    );

    pdec_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept && grp_nonempty),
        .i_group    (grp),
        .o_can_load (can_load),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_byte     (m_axis_tdata),
        .o_term     (m_axis_tuser),
        .o_last     (m_axis_tlast)
    );

endmodule

// File: test/percent_decoder_chk.sv
// Checker for the percent decoder: predicts result beats from accepted input beats and compares.
module percent_decoder_chk import pdec_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [7:0]  m_axis_tdata,
    input  logic        m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_term;
        logic       run_end;
    } t_decoded;

    t_decoded    decoded_q[$];
    logic [15:0] capacity;
    logic [1:0]  phase;
    logic [7:0]  held_digit;
    logic [15:0] emitted;
    int          fails;

    // Return {valid, nibble} for one ASCII hex digit of either case
    function automatic logic [4:0] hex_nibble(input logic [7:0] b);
        logic [4:0] h;
        h = 5'd0;
        if (b >= C_DIG0 && b <= C_DIG9) begin
            h = {1'b1, 4'(b - C_DIG0)};
        end else if (b >= C_UPA && b <= C_UPF) begin
            h = {1'b1, 4'(b - C_UPA + 8'd10)};
        end else if (b >= C_LOA && b <= C_LOF) begin
            h = {1'b1, 4'(b - C_LOA + 8'd10)};
        end
        return h;
    endfunction

    // Queue one decoded byte unless the destination is full
    task automatic emit_byte(input logic [7:0] b);
        t_decoded r;
        if ({1'b0, emitted} + 17'd1 < {1'b0, capacity}) begin
            r.out_byte = b;
            r.is_term  = 1'b0;
            r.run_end  = 1'b0;
            decoded_q.push_back(r);
            emitted = emitted + 16'd1;
        end
    endtask

    // Handle a byte outside any escape
    task automatic plain_byte(input logic [7:0] b, input logic last);
        if (b == C_PLUS) begin
            emit_byte(C_SPACE);
        end else if (b == C_PERCENT && !last) begin
            phase = PH_PCT;
        end else begin
            emit_byte(b);
        end
    endtask

    // Advance the decoder by one raw byte and queue the results it causes
    task automatic decode_byte(input logic [7:0] b, input logic last);
        int         base;
        logic [4:0] first;
        logic [4:0] second;
        t_decoded   r;
        base   = decoded_q.size();
        second = hex_nibble(b);
        case (phase)
            PH_PCT: begin
                phase = PH_IDLE;
                if (!last && second[4]) begin
                    held_digit = b;
                    phase      = PH_DIGIT;
                end else begin
                    emit_byte(C_PERCENT);
                    plain_byte(b, last);
                end
            end
            PH_DIGIT: begin
                phase = PH_IDLE;
                first = hex_nibble(held_digit);
                if (first[4] && second[4]) begin
                    emit_byte({first[3:0], second[3:0]});
                end else begin
                    emit_byte(C_PERCENT);
                    emit_byte(held_digit);
                    plain_byte(b, last);
                end
                held_digit = 8'd0;
            end
            default: begin
                phase = PH_IDLE;
                plain_byte(b, last);
            end
        endcase
        // Close the string with a terminator and clear the escape state
        if (last) begin
            r.out_byte = 8'd0;
            r.is_term  = 1'b1;
            r.run_end  = 1'b0;
            decoded_q.push_back(r);
            phase      = PH_IDLE;
            held_digit = 8'd0;
            emitted    = 16'd0;
        end
        // Mark the last result of this input beat
        if (decoded_q.size() > base) begin
            r = decoded_q.pop_back();
            r.run_end = 1'b1;
            decoded_q.push_back(r);
        end
    endtask

    initial begin
        capacity   = CAP_RESET;
        phase      = PH_IDLE;
        held_digit = 8'd0;
        emitted    = 16'd0;
        fails      = 0;
    end

    // Watch all three channels; compare result beats before predicting new ones
    always @(posedge i_clk) begin
        t_decoded want;
        if (!i_rst_n) begin
            capacity   = CAP_RESET;
            phase      = PH_IDLE;
            held_digit = 8'd0;
            emitted    = 16'd0;
            decoded_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result beat: out_byte %0h is_terminator %0b run_end %0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fails++;
                end else begin
                    want = decoded_q.pop_front();
                    if (m_axis_tdata !== want.out_byte) begin
                        $error("out_byte: expected %0h, got %0h", want.out_byte, m_axis_tdata);
                        fails++;
                    end
                    if (m_axis_tuser !== want.is_term) begin
                        $error("is_terminator: expected %0b, got %0b",
                               want.is_term, m_axis_tuser);
                        fails++;
                    end
                    if (m_axis_tlast !== want.run_end) begin
                        $error("run_end: expected %0b, got %0b", want.run_end, m_axis_tlast);
                        fails++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                capacity = i_cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tlast);
            end
        end
        o_pending    <= decoded_q.size();
        o_fail_count <= fails;
    end

endmodule

// File: test/tb.sv
// Testbench top for the percent decoder: drives strings and capacity writes, gives the verdict.
module tb import pdec_pkg::*;;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_data    = 16'd0;

    int          fail_count;
    int          pending;
    int          sent_bytes    = 0;
    logic        send_quiet    = 1'b0;
    logic        sink_quiet    = 1'b0;

    percent_decoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    percent_decoder_chk chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hold each raw byte on the input until its beat is taken
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_bytes++;
    endtask

    task automatic send_text(input string txt, input logic ends);
        for (int i = 0; i < txt.len(); i++) begin
            send_byte(txt[i], ends && (i == txt.len() - 1));
        end
    endtask

    // Drop valid and let every expected result drain, then allow the pipeline to empty
    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [15:0] cap);
        drain();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= cap;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] rand_hex_digit;
        logic [7:0] v;
        v = 8'($urandom_range(0, 15));
        if (v < 8'd10) begin
            return C_DIG0 + v;
        end
        return ($urandom_range(0, 1) ? C_UPA : C_LOA) + v - 8'd10;
    endfunction

    // Build one string of mostly well-formed escapes with some noise, then send it
    task automatic send_random_string;
        logic [7:0] text[$];
        int         len;
        len = $urandom_range(1, 12);
        while (text.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1, 2: text.push_back(8'($urandom_range(32, 126)));
                3:       text.push_back(C_PLUS);
                4, 5, 6: begin
                    text.push_back(C_PERCENT);
                    text.push_back(rand_hex_digit());
                    text.push_back(rand_hex_digit());
                end
                7: begin
                    text.push_back(C_PERCENT);
                    if ($urandom_range(0, 1)) begin
                        text.push_back(rand_hex_digit());
                    end
                    text.push_back(8'($urandom_range(0, 255)));
                end
                8:       text.push_back(8'($urandom_range(0, 255)));
                default: text.push_back(C_PERCENT);
            endcase
        end
        send_quiet = ($urandom_range(0, 4) == 0);
        foreach (text[i]) begin
            send_byte(text[i], i == text.size() - 1);
        end
    endtask

    // Stall the result side at random before each beat, apart from quiet spells with no stall
    initial begin
        int stall;
        @(negedge i_clk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                sink_quiet = !sink_quiet;
            end
            stall = sink_quiet ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // Main sequence: reset, directed strings, then random strings per capacity setting
    initial begin
        logic [15:0] caps[8];
        int          start;
        int          waited;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed strings at reset capacity
        send_text("a+%41%6f", 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("%G%4Z", 1'b1);
        send_text("%%4a%4%", 1'b1);
        send_text("%4", 1'b1);
        send_text("%", 1'b1);

        // Shrink the capacity partway through a string
        send_text("ab", 1'b0);
        write_capacity(16'd3);
        send_text("c%41", 1'b1);

        caps[0] = 16'd1;
        caps[1] = 16'hFFFF;
        caps[2] = 16'd0;
        caps[3] = 16'd2;
        caps[4] = 16'd7;
        caps[5] = CAP_RESET;
        caps[6] = 16'($urandom_range(3, 64));
        caps[7] = 16'($urandom_range(0, 65535));
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            start = sent_bytes;
            while (sent_bytes - start < 38) begin
                send_random_string();
            end
        end

        // Wait out the last results, with a limit
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        waited = 0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (pending != 0 && waited < 2000);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("percent_decoder regression: pass");
        end else begin
            $display("percent_decoder regression: fail");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("percent_decoder regression: fail");
        $finish;
    end

endmodule
